// ===== hdl/sttc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the sorted time table core.
// No dependencies; used by sttc_cell and sorted_time_table_core.
package sttc_pkg;

  localparam int TIME_W  = 18;
  localparam int STOP_W  = 16;
  localparam int TAG_W   = 16;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 9;
  localparam int OVER_W  = 18;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 88;

  localparam int GROUP_W = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_TAG    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] time_v;
    logic [STOP_W-1:0] stop_v;
    logic [TAG_W-1:0]  tag_v;
  } entry_t;

  typedef struct packed {
    logic below;   // stored time < key
    logic above;   // stored time > key
    logic match;   // live entry with tag equal to key tag
  } flags_t;

endpackage

// ===== hdl/sttc_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted table: holds an entry, shifts up on insert, compares against the key.
// Depends on sttc_pkg.
module sttc_cell #(
  parameter int TABLE_DEPTH = 256,
  parameter int IDX         = 0
) (
  input  logic                             clk,
  input  logic                             ins_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   ins_pos,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
  input  sttc_pkg::entry_t                 key,
  input  sttc_pkg::entry_t                 prev,
  output sttc_pkg::entry_t                 entry,
  output sttc_pkg::flags_t                 flags
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
  localparam logic [CW-1:0] MY_IDXC = CW'(IDX);

  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (MY_IDX > ins_pos) begin
        entry <= prev;
      end else if (MY_IDX == ins_pos) begin
        entry <= key;
      end
    end
  end

  always_ff @(posedge clk) begin
    flags.below <= entry.time_v < key.time_v;
    flags.above <= entry.time_v > key.time_v;
    flags.match <= (entry.tag_v == key.tag_v) && (MY_IDXC < count);
  end

endmodule

// ===== hdl/sorted_time_table_core.sv =====
`timescale 1ns / 1ps
// Sorted time table: insert, find latest at or before a time, read by index, find by tag.
// One item at a time; the next transfer is taken the cycle after the result is registered.
// Steps: read and a full insert go from CMP straight to FIN; insert and find latest bisect the
// sorted entries in BISECT, and insert then shifts the cells in SHIFT; find by tag scans groups
// of 16 slots in SCAN (at most TABLE_DEPTH/16 groups, rounded up). A held result stalls the
// next item in FIN. Synchronous reset empties the table and clears the overage.
module sorted_time_table_core #(
  parameter int TABLE_DEPTH     = 256,
  parameter int SECONDS_PER_DAY = 86400
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // op[1:0], key_time[19:2], stop_seq_in[35:20], trip_tag_in[51:36], entry_index[59:52]
  input  logic [sttc_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status[1:0], found_index[9:2], found_time[27:10], found_stop_seq[43:28],
  // found_trip_tag[59:44], entry_total[68:60], overage_out[86:69]
  output logic [sttc_pkg::M_TDATA_W-1:0]     m_tdata
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int G   = sttc_pkg::GROUP_W;
  localparam int NG  = (TABLE_DEPTH + G - 1) / G;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW  = GW + $clog2(G);

  localparam logic [2:0] IDLE   = 3'd0;
  localparam logic [2:0] CMP    = 3'd1;
  localparam logic [2:0] BISECT = 3'd2;
  localparam logic [2:0] SCAN   = 3'd3;
  localparam logic [2:0] SHIFT  = 3'd4;
  localparam logic [2:0] FIN    = 3'd5;

  logic [2:0]                    state;
  logic [sttc_pkg::OP_W-1:0]     op;
  sttc_pkg::entry_t              key_ent;
  logic [sttc_pkg::IDX_W-1:0]    idx;
  logic [CW-1:0]                 first;
  logic [CW-1:0]                 hi;
  logic [GW-1:0]                 grp;
  logic [IW-1:0]                 pos;
  logic [sttc_pkg::STAT_W-1:0]   status;
  logic                          have;
  logic [CW-1:0]                 count;
  logic [sttc_pkg::OVER_W-1:0]   overage;

  sttc_pkg::entry_t cell_entry [TABLE_DEPTH];
  sttc_pkg::flags_t cell_flags [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] below_vec;
  logic [TABLE_DEPTH-1:0] above_vec;
  logic [NG*G-1:0]        match_pad;

  logic [CW:0]   mid_sum;
  logic [IW-1:0] mid;
  logic [G-1:0]  grp_bits;
  logic [$clog2(G)-1:0] grp_enc;
  logic [PW-1:0] scan_pos;
  logic          ins_en;
  sttc_pkg::entry_t out_ent;

  assign ins_en = (state == SHIFT);

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      sttc_pkg::entry_t prev_ent;
      if (gi == 0) begin : g_head
        assign prev_ent = key_ent;
      end else begin : g_body
        assign prev_ent = cell_entry[gi-1];
      end
      sttc_cell #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IDX        (gi)
      ) u_cell (
        .clk    (clk),
        .ins_en (ins_en),
        .ins_pos(pos),
        .count  (count),
        .key    (key_ent),
        .prev   (prev_ent),
        .entry  (cell_entry[gi]),
        .flags  (cell_flags[gi])
      );
      assign below_vec[gi] = cell_flags[gi].below;
      assign above_vec[gi] = cell_flags[gi].above;
      assign match_pad[gi] = cell_flags[gi].match;
    end
    if (NG * G > TABLE_DEPTH) begin : g_pad
      assign match_pad[NG*G-1:TABLE_DEPTH] = '0;
    end
  endgenerate

  assign mid_sum  = {1'b0, first} + {1'b0, hi} - 1'b1;
  assign mid      = mid_sum[IW:1];
  assign grp_bits = match_pad[grp*G +: G];
  assign scan_pos = {grp, grp_enc};
  assign out_ent  = cell_entry[pos];

  always_comb begin
    grp_enc = '0;
    for (int i = G - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        grp_enc = ($clog2(G))'(i);
      end
    end
  end

  assign s_tready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      overage  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            op             <= s_tdata[1:0];
            key_ent.time_v <= s_tdata[19:2];
            key_ent.stop_v <= s_tdata[35:20];
            key_ent.tag_v  <= s_tdata[51:36];
            idx            <= s_tdata[59:52];
            state          <= CMP;
          end
        end
        CMP: begin
          first  <= '0;
          hi     <= count;
          grp    <= '0;
          unique case (op)
            sttc_pkg::OP_INSERT: begin
              have <= 1'b0;
              if (count == CW'(TABLE_DEPTH)) begin
                status <= sttc_pkg::ST_FULL;
                state  <= FIN;
              end else begin
                status <= sttc_pkg::ST_OK;
                if ({1'b0, key_ent.time_v} >
                    19'(SECONDS_PER_DAY) + {1'b0, overage}) begin
                  overage <= 18'(key_ent.time_v - 18'(SECONDS_PER_DAY));
                end
                state <= BISECT;
              end
            end
            sttc_pkg::OP_FIND: begin
              status <= sttc_pkg::ST_OK;
              have   <= 1'b0;
              state  <= BISECT;
            end
            sttc_pkg::OP_READ: begin
              if (int'(idx) >= int'(count)) begin
                status <= sttc_pkg::ST_RANGE;
                have   <= 1'b0;
              end else begin
                status <= sttc_pkg::ST_OK;
                pos    <= IW'(idx);
                have   <= 1'b1;
              end
              state <= FIN;
            end
            default: begin
              status <= sttc_pkg::ST_OK;
              have   <= 1'b0;
              state  <= SCAN;
            end
          endcase
        end
        BISECT: begin
          if (first >= hi) begin
            if (op == sttc_pkg::OP_INSERT) begin
              pos   <= IW'(first);
              have  <= 1'b1;
              state <= SHIFT;
            end else if (first == '0) begin
              status <= sttc_pkg::ST_NOT_FOUND;
              state  <= FIN;
            end else begin
              pos   <= IW'(first - 1'b1);
              have  <= 1'b1;
              state <= FIN;
            end
          end else if (below_vec[mid]) begin
            first <= CW'(mid) + 1'b1;
          end else if (above_vec[mid]) begin
            hi <= CW'(mid);
          end else begin
            pos   <= mid;
            have  <= 1'b1;
            state <= (op == sttc_pkg::OP_INSERT) ? SHIFT : FIN;
          end
        end
        SCAN: begin
          if (grp_bits != '0) begin
            pos   <= IW'(scan_pos);
            have  <= 1'b1;
            state <= FIN;
          end else if (grp == GW'(NG - 1)) begin
            status <= sttc_pkg::ST_NOT_FOUND;
            state  <= FIN;
          end else begin
            grp <= grp + 1'b1;
          end
        end
        SHIFT: begin
          count <= count + 1'b1;
          state <= FIN;
        end
        FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == FIN && (!m_tvalid || m_tready)) begin
      m_tdata[1:0]   <= status;
      m_tdata[9:2]   <= have ? 8'(pos) : '0;
      m_tdata[27:10] <= have ? out_ent.time_v : '0;
      m_tdata[43:28] <= have ? out_ent.stop_v : '0;
      m_tdata[59:44] <= have ? out_ent.tag_v : '0;
      m_tdata[68:60] <= 9'(count);
      m_tdata[86:69] <= overage;
      m_tdata[87]    <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_bisect_order: assert property (@(posedge clk) disable iff (rst)
    (state == BISECT) |-> (first <= hi) && (hi <= count))
    else $error("bisection bounds crossed");

  a_shift_grows: assert property (@(posedge clk) disable iff (rst)
    (state == SHIFT) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the table");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == FIN && status == sttc_pkg::ST_FULL) |-> (count == CW'(TABLE_DEPTH)))
    else $error("full reported on a table with room");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (state == FIN && status != sttc_pkg::ST_OK) |-> !have)
    else $error("entry reported with an error status");

endmodule
